### rtl/blr_pkg.sv
`timescale 1ns / 1ps

package blr_pkg;

   localparam int COORD_BITS_DEFAULT = 12;
   localparam int QUEUE_DEPTH_DEFAULT = 2;
   localparam int COLOR_BITS = 32;

   localparam logic [COLOR_BITS-1:0] PEN_COLOR_RESET = 32'h00FF_FFFF;

   typedef logic [1:0] move_type;

   localparam move_type MOVE_NONE = 2'd0;
   localparam move_type MOVE_INC  = 2'd1;
   localparam move_type MOVE_DEC  = 2'd3;

   localparam logic CMD_START   = 1'b0;
   localparam logic CMD_ADVANCE = 1'b1;

endpackage

### rtl/bresenham_line_rasterizer_unit.sv
// An accepted request word passes the front register, the queue and the back output register before its response word.
// Throughput: one word per cycle while neither side stalls, set by the error update in the back stage.
// A two-entry queue between front and back lets either side stall on its own.
// Reset is synchronous and active high; it ends any line and sets the pen color
// to 0x00FFFFFF.
`timescale 1ns / 1ps

module bresenham_line_rasterizer_unit
   import blr_pkg::*;
#(
   parameter int COORD_BITS  = COORD_BITS_DEFAULT,
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_enable,
   input  logic [COLOR_BITS-1:0] csr_write_data,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_command,
   input  logic [COORD_BITS-1:0] req_start_x,
   input  logic [COORD_BITS-1:0] req_start_y,
   input  logic [COORD_BITS-1:0] req_end_x,
   input  logic [COORD_BITS-1:0] req_end_y,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [COORD_BITS-1:0] rsp_pixel_x,
   output logic [COORD_BITS-1:0] rsp_pixel_y,
   output logic [COLOR_BITS-1:0] rsp_pixel_color,
   output logic                  rsp_valid_res,
   output logic                  rsp_last
);

   localparam int ITEM_BITS = 4 * COORD_BITS + 9;

   logic                 push_valid;
   logic                 push_full;
   logic [ITEM_BITS-1:0] push_data;
   logic                 pop_valid;
   logic                 pop_ready;
   logic [ITEM_BITS-1:0] pop_data;

   blr_front #(
      .COORD_BITS(COORD_BITS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_command (req_command),
      .req_start_x (req_start_x),
      .req_start_y (req_start_y),
      .req_end_x   (req_end_x),
      .req_end_y   (req_end_y),
      .push_valid  (push_valid),
      .push_full   (push_full),
      .push_data   (push_data)
   );

   blr_queue #(
      .WIDTH(ITEM_BITS),
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_full  (push_full),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   blr_back #(
      .COORD_BITS(COORD_BITS)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .pop_valid        (pop_valid),
      .pop_ready        (pop_ready),
      .pop_data         (pop_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_pixel_x      (rsp_pixel_x),
      .rsp_pixel_y      (rsp_pixel_y),
      .rsp_pixel_color  (rsp_pixel_color),
      .rsp_valid_res    (rsp_valid_res),
      .rsp_last         (rsp_last)
   );

endmodule

### rtl/blr_front.sv
`timescale 1ns / 1ps

module blr_front
   import blr_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEFAULT,
   localparam int ITEM_BITS = 4 * COORD_BITS + 9
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_command,
   input  logic [COORD_BITS-1:0] req_start_x,
   input  logic [COORD_BITS-1:0] req_start_y,
   input  logic [COORD_BITS-1:0] req_end_x,
   input  logic [COORD_BITS-1:0] req_end_y,
   output logic                  push_valid,
   input  logic                  push_full,
   output logic [ITEM_BITS-1:0]  push_data
);

   typedef struct packed {
      logic                  is_start;
      logic [COORD_BITS-1:0] x;
      logic [COORD_BITS-1:0] y;
      logic [COORD_BITS-1:0] limit;
      logic [COORD_BITS-1:0] step;
      move_type              major_x;
      move_type              major_y;
      move_type              minor_x;
      move_type              minor_y;
   } item_type;

   logic                  front_valid_ff;
   logic                  front_valid_in;
   item_type              item_ff;
   item_type              item_in;
   logic                  accept;
   logic                  push;
   logic [COORD_BITS-1:0] dx;
   logic [COORD_BITS-1:0] dy;
   move_type              sx;
   move_type              sy;
   logic                  x_major;

   assign req_stall  = front_valid_ff & push_full;
   assign accept     = req_valid & ~req_stall;
   assign push       = front_valid_ff & ~push_full;
   assign push_valid = front_valid_ff;
   assign push_data  = item_ff;

   // Work out the deltas, directions and major axis of a start word.
   always_comb begin
      dx      = (req_end_x >= req_start_x) ? (req_end_x - req_start_x)
                                           : (req_start_x - req_end_x);
      dy      = (req_end_y >= req_start_y) ? (req_end_y - req_start_y)
                                           : (req_start_y - req_end_y);
      sx      = (req_end_x >= req_start_x) ? MOVE_INC : MOVE_DEC;
      sy      = (req_end_y >= req_start_y) ? MOVE_INC : MOVE_DEC;
      x_major = (dx >= dy);

      item_in.is_start = (req_command == CMD_START);
      item_in.x        = req_start_x;
      item_in.y        = req_start_y;
      if (x_major) begin
         item_in.limit   = dx;
         item_in.step    = dy;
         item_in.major_x = sx;
         item_in.major_y = MOVE_NONE;
         item_in.minor_x = MOVE_NONE;
         item_in.minor_y = sy;
      end else begin
         item_in.limit   = dy;
         item_in.step    = dx;
         item_in.major_x = MOVE_NONE;
         item_in.major_y = sy;
         item_in.minor_x = sx;
         item_in.minor_y = MOVE_NONE;
      end
   end

   always_comb begin
      if (accept) begin
         front_valid_in = 1'b1;
      end else if (push) begin
         front_valid_in = 1'b0;
      end else begin
         front_valid_in = front_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_valid_ff <= 1'b0;
      end else begin
         front_valid_ff <= front_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= item_in;
      end
   end

endmodule

### rtl/blr_queue.sv
`timescale 1ns / 1ps

module blr_queue
   import blr_pkg::*;
#(
   parameter int WIDTH = 8,
   parameter int DEPTH = QUEUE_DEPTH_DEFAULT,
   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int CNT_BITS = $clog2(DEPTH + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_full,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);

   logic [WIDTH-1:0]    entry_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff;
   logic [PTR_BITS-1:0] wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff;
   logic [PTR_BITS-1:0] rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff;
   logic [CNT_BITS-1:0] count_in;
   logic                push;
   logic                pop;

   assign push_full = (count_ff == CNT_BITS'(DEPTH));
   assign pop_valid = (count_ff != '0);
   assign push      = push_valid & ~push_full;
   assign pop       = pop_valid & pop_ready;
   assign pop_data  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### rtl/blr_back.sv
`timescale 1ns / 1ps

module blr_back
   import blr_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEFAULT,
   localparam int ITEM_BITS = 4 * COORD_BITS + 9
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_enable,
   input  logic [COLOR_BITS-1:0] csr_write_data,
   input  logic                  pop_valid,
   output logic                  pop_ready,
   input  logic [ITEM_BITS-1:0]  pop_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [COORD_BITS-1:0] rsp_pixel_x,
   output logic [COORD_BITS-1:0] rsp_pixel_y,
   output logic [COLOR_BITS-1:0] rsp_pixel_color,
   output logic                  rsp_valid_res,
   output logic                  rsp_last
);

   typedef struct packed {
      logic                  is_start;
      logic [COORD_BITS-1:0] x;
      logic [COORD_BITS-1:0] y;
      logic [COORD_BITS-1:0] limit;
      logic [COORD_BITS-1:0] step;
      move_type              major_x;
      move_type              major_y;
      move_type              minor_x;
      move_type              minor_y;
   } item_type;

   function automatic logic [COORD_BITS-1:0] move_coord(input logic [COORD_BITS-1:0] c,
                                                        input move_type code);
      logic [COORD_BITS-1:0] result;
      case (code)
         MOVE_INC: result = c + 1'b1;
         MOVE_DEC: result = c - 1'b1;
         default:  result = c;
      endcase
      return result;
   endfunction

   item_type              item;
   logic                  fire;

   logic [COLOR_BITS-1:0] pen_color_ff;
   logic [COORD_BITS-1:0] cur_x_ff;
   logic [COORD_BITS-1:0] cur_x_in;
   logic [COORD_BITS-1:0] cur_y_ff;
   logic [COORD_BITS-1:0] cur_y_in;
   logic [COORD_BITS:0]   accum_ff;
   logic [COORD_BITS:0]   accum_in;
   logic [COORD_BITS-1:0] limit_ff;
   logic [COORD_BITS-1:0] limit_in;
   logic [COORD_BITS-1:0] step_ff;
   logic [COORD_BITS-1:0] step_in;
   move_type              major_x_ff;
   move_type              major_x_in;
   move_type              major_y_ff;
   move_type              major_y_in;
   move_type              minor_x_ff;
   move_type              minor_x_in;
   move_type              minor_y_ff;
   move_type              minor_y_in;
   logic [COORD_BITS-1:0] left_ff;
   logic [COORD_BITS-1:0] left_in;
   logic                  active_ff;
   logic                  active_in;

   logic                  out_valid_ff;
   logic                  out_valid_in;
   logic [COORD_BITS-1:0] out_x_ff;
   logic [COORD_BITS-1:0] out_x_in;
   logic [COORD_BITS-1:0] out_y_ff;
   logic [COORD_BITS-1:0] out_y_in;
   logic [COLOR_BITS-1:0] out_color_ff;
   logic [COLOR_BITS-1:0] out_color_in;
   logic                  out_res_ff;
   logic                  out_res_in;
   logic                  out_last_ff;
   logic                  out_last_in;

   logic [COORD_BITS:0]   sum;
   logic                  take_minor;
   logic [COORD_BITS-1:0] mid_x;
   logic [COORD_BITS-1:0] mid_y;
   logic [COORD_BITS-1:0] left_dec;

   assign item      = pop_data;
   assign pop_ready = ~out_valid_ff | ~rsp_stall;
   assign fire      = pop_valid & pop_ready;

   assign rsp_valid       = out_valid_ff;
   assign rsp_pixel_x     = out_x_ff;
   assign rsp_pixel_y     = out_y_ff;
   assign rsp_pixel_color = out_color_ff;
   assign rsp_valid_res   = out_res_ff;
   assign rsp_last        = out_last_ff;

   always_comb begin
      sum        = accum_ff + {1'b0, step_ff};
      take_minor = (sum >= {1'b0, limit_ff});
      mid_x      = take_minor ? move_coord(cur_x_ff, minor_x_ff) : cur_x_ff;
      mid_y      = take_minor ? move_coord(cur_y_ff, minor_y_ff) : cur_y_ff;
      left_dec   = left_ff - 1'b1;

      cur_x_in   = cur_x_ff;
      cur_y_in   = cur_y_ff;
      accum_in   = accum_ff;
      limit_in   = limit_ff;
      step_in    = step_ff;
      major_x_in = major_x_ff;
      major_y_in = major_y_ff;
      minor_x_in = minor_x_ff;
      minor_y_in = minor_y_ff;
      left_in    = left_ff;
      active_in  = active_ff;

      out_valid_in = out_valid_ff & rsp_stall;
      out_x_in     = out_x_ff;
      out_y_in     = out_y_ff;
      out_color_in = out_color_ff;
      out_res_in   = out_res_ff;
      out_last_in  = out_last_ff;

      if (fire) begin
         out_valid_in = 1'b1;
         if (item.is_start) begin
            cur_x_in     = item.x;
            cur_y_in     = item.y;
            accum_in     = {2'b00, item.limit[COORD_BITS-1:1]};
            limit_in     = item.limit;
            step_in      = item.step;
            major_x_in   = item.major_x;
            major_y_in   = item.major_y;
            minor_x_in   = item.minor_x;
            minor_y_in   = item.minor_y;
            left_in      = item.limit;
            active_in    = (item.limit != '0);
            out_x_in     = item.x;
            out_y_in     = item.y;
            out_color_in = pen_color_ff;
            out_res_in   = 1'b1;
            out_last_in  = (item.limit == '0);
         end else if (active_ff) begin
            accum_in     = take_minor ? (sum - {1'b0, limit_ff}) : sum;
            cur_x_in     = move_coord(mid_x, major_x_ff);
            cur_y_in     = move_coord(mid_y, major_y_ff);
            left_in      = left_dec;
            active_in    = (left_dec != '0);
            out_x_in     = cur_x_in;
            out_y_in     = cur_y_in;
            out_color_in = pen_color_ff;
            out_res_in   = 1'b1;
            out_last_in  = (left_dec == '0);
         end else begin
            out_x_in     = '0;
            out_y_in     = '0;
            out_color_in = '0;
            out_res_in   = 1'b0;
            out_last_in  = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pen_color_ff <= PEN_COLOR_RESET;
         cur_x_ff     <= '0;
         cur_y_ff     <= '0;
         accum_ff     <= '0;
         limit_ff     <= '0;
         step_ff      <= '0;
         major_x_ff   <= MOVE_NONE;
         major_y_ff   <= MOVE_NONE;
         minor_x_ff   <= MOVE_NONE;
         minor_y_ff   <= MOVE_NONE;
         left_ff      <= '0;
         active_ff    <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            pen_color_ff <= csr_write_data;
         end
         cur_x_ff     <= cur_x_in;
         cur_y_ff     <= cur_y_in;
         accum_ff     <= accum_in;
         limit_ff     <= limit_in;
         step_ff      <= step_in;
         major_x_ff   <= major_x_in;
         major_y_ff   <= major_y_in;
         minor_x_ff   <= minor_x_in;
         minor_y_ff   <= minor_y_in;
         left_ff      <= left_in;
         active_ff    <= active_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_x_ff     <= out_x_in;
      out_y_ff     <= out_y_in;
      out_color_ff <= out_color_in;
      out_res_ff   <= out_res_in;
      out_last_ff  <= out_last_in;
   end

endmodule

### rtl/blr_checker.sv
`timescale 1ns / 1ps

module blr_checker
   import blr_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_stall,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input logic [COORD_BITS-1:0] rsp_pixel_x,
   input logic [COORD_BITS-1:0] rsp_pixel_y,
   input logic [COLOR_BITS-1:0] rsp_pixel_color,
   input logic                  rsp_valid_res,
   input logic                  rsp_last
);

   // After reset no response word is offered.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response word offered right after reset");

   // A stalled response word stays offered and unchanged.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_pixel_x) && $stable(rsp_pixel_y)
         && $stable(rsp_pixel_color) && $stable(rsp_valid_res) && $stable(rsp_last))
      else $error("stalled response word changed");

   // A word without a pixel carries all fields at zero.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_valid_res |-> rsp_pixel_x == '0 && rsp_pixel_y == '0
         && rsp_pixel_color == '0 && !rsp_last)
      else $error("empty response word carries nonzero fields");

   // The request side only starts to stall right after it took a word.
   assert property (@(posedge clock) disable iff (reset)
      $rose(req_stall) |-> $past(req_valid && !req_stall))
      else $error("request stall rose without a prior accepted word");

endmodule

bind bresenham_line_rasterizer_unit blr_checker #(
   .COORD_BITS(COORD_BITS)
) u_blr_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_pixel_x     (rsp_pixel_x),
   .rsp_pixel_y     (rsp_pixel_y),
   .rsp_pixel_color (rsp_pixel_color),
   .rsp_valid_res   (rsp_valid_res),
   .rsp_last        (rsp_last)
);

### tb/tb_bresenham_line_rasterizer_unit.sv
`timescale 1ns / 1ps

module tb_bresenham_line_rasterizer_unit;
   import blr_pkg::*;

   localparam int XY_BITS = COORD_BITS_DEFAULT;
   localparam int XY_MAX = (1 << XY_BITS) - 1;
   localparam int SETTLE_CYCLES = 8;
   localparam int WATCHDOG_LIMIT = 4000;

   typedef struct packed {
      logic [XY_BITS-1:0]    x;
      logic [XY_BITS-1:0]    y;
      logic [COLOR_BITS-1:0] color;
      logic                  drawn;
      logic                  is_last;
   } pixel_type;

   logic                  clock;
   logic                  reset = 1'b1;
   logic                  csr_write_enable = 1'b0;
   logic [COLOR_BITS-1:0] csr_write_data = '0;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic                  req_command = CMD_START;
   logic [XY_BITS-1:0]    req_start_x = '0;
   logic [XY_BITS-1:0]    req_start_y = '0;
   logic [XY_BITS-1:0]    req_end_x = '0;
   logic [XY_BITS-1:0]    req_end_y = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [XY_BITS-1:0]    rsp_pixel_x;
   logic [XY_BITS-1:0]    rsp_pixel_y;
   logic [COLOR_BITS-1:0] rsp_pixel_color;
   logic                  rsp_valid_res;
   logic                  rsp_last;

   bresenham_line_rasterizer_unit dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_command      (req_command),
      .req_start_x      (req_start_x),
      .req_start_y      (req_start_y),
      .req_end_x        (req_end_x),
      .req_end_y        (req_end_y),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_pixel_x      (rsp_pixel_x),
      .rsp_pixel_y      (rsp_pixel_y),
      .rsp_pixel_color  (rsp_pixel_color),
      .rsp_valid_res    (rsp_valid_res),
      .rsp_last         (rsp_last)
   );

   // Line state mirrored from the words accepted so far.
   logic [XY_BITS-1:0]    pos_x, pos_y;
   logic [XY_BITS:0]      err_term;
   logic [XY_BITS-1:0]    major_span, minor_span;
   move_type              major_x, major_y, minor_x, minor_y;
   logic [XY_BITS-1:0]    pixels_to_go;
   logic                  line_on;
   logic [COLOR_BITS-1:0] pen_color_now;

   pixel_type expected_pixels[$];
   pixel_type want_pixel, got_pixel;
   int     mismatch_count = 0;
   int     quiet_cycles = 0;
   int     words_sent = 0;
   int     hold_len = 0;
   bit     gaps_on = 1'b1;
   bit     stalls_on = 1'b1;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [XY_BITS-1:0] shift_coord(logic [XY_BITS-1:0] c, move_type m);
      if (m == MOVE_INC) begin
         return c + 1'b1;
      end
      if (m == MOVE_DEC) begin
         return c - 1'b1;
      end
      return c;
   endfunction

   function automatic pixel_type rasterize(logic cmd, logic [XY_BITS-1:0] x1,
                                           logic [XY_BITS-1:0] y1,
                                           logic [XY_BITS-1:0] x2, logic [XY_BITS-1:0] y2);
      pixel_type          p;
      logic [XY_BITS-1:0] dx, dy;
      move_type           sx, sy;
      p = '0;
      if (cmd == CMD_START) begin
         dx = (x2 >= x1) ? x2 - x1 : x1 - x2;
         dy = (y2 >= y1) ? y2 - y1 : y1 - y2;
         sx = (x2 >= x1) ? MOVE_INC : MOVE_DEC;
         sy = (y2 >= y1) ? MOVE_INC : MOVE_DEC;
         pos_x = x1;
         pos_y = y1;
         if (dx >= dy) begin
            major_x = sx;
            major_y = MOVE_NONE;
            minor_x = MOVE_NONE;
            minor_y = sy;
            major_span = dx;
            minor_span = dy;
         end else begin
            major_x = MOVE_NONE;
            major_y = sy;
            minor_x = sx;
            minor_y = MOVE_NONE;
            major_span = dy;
            minor_span = dx;
         end
         err_term = {1'b0, major_span} >> 1;
         pixels_to_go = major_span;
      end else if (!line_on) begin
         return p;
      end else begin
         err_term = err_term + {1'b0, minor_span};
         if (err_term >= {1'b0, major_span}) begin
            err_term = err_term - {1'b0, major_span};
            pos_x = shift_coord(pos_x, minor_x);
            pos_y = shift_coord(pos_y, minor_y);
         end
         pos_x = shift_coord(pos_x, major_x);
         pos_y = shift_coord(pos_y, major_y);
         pixels_to_go = pixels_to_go - 1'b1;
      end
      line_on = (pixels_to_go != 0);
      p.x = pos_x;
      p.y = pos_y;
      p.color = pen_color_now;
      p.drawn = 1'b1;
      p.is_last = (pixels_to_go == 0);
      return p;
   endfunction

   function automatic void check_field(string name, logic [COLOR_BITS-1:0] want,
                                       logic [COLOR_BITS-1:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
         mismatch_count++;
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         pos_x = '0;
         pos_y = '0;
         err_term = '0;
         major_span = '0;
         minor_span = '0;
         major_x = MOVE_NONE;
         major_y = MOVE_NONE;
         minor_x = MOVE_NONE;
         minor_y = MOVE_NONE;
         pixels_to_go = '0;
         line_on = 1'b0;
         pen_color_now = PEN_COLOR_RESET;
         expected_pixels.delete();
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (req_valid === 1'b1 && req_stall === 1'b0) begin
            expected_pixels.push_back(rasterize(req_command, req_start_x, req_start_y,
                                                req_end_x, req_end_y));
            quiet_cycles = 0;
         end
         if (rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
            quiet_cycles = 0;
            got_pixel = {rsp_pixel_x, rsp_pixel_y, rsp_pixel_color, rsp_valid_res, rsp_last};
            if (expected_pixels.size() == 0) begin
               $display("%0t: unexpected word, expected none, actual 0x%0h", $time, got_pixel);
               mismatch_count++;
            end else begin
               want_pixel = expected_pixels.pop_front();
               check_field("pixel_x", COLOR_BITS'(want_pixel.x), COLOR_BITS'(got_pixel.x));
               check_field("pixel_y", COLOR_BITS'(want_pixel.y), COLOR_BITS'(got_pixel.y));
               check_field("pixel_color", want_pixel.color, got_pixel.color);
               check_field("valid_res", COLOR_BITS'(want_pixel.drawn),
                           COLOR_BITS'(got_pixel.drawn));
               check_field("last", COLOR_BITS'(want_pixel.is_last),
                           COLOR_BITS'(got_pixel.is_last));
            end
         end
         if (csr_write_enable === 1'b1) begin
            pen_color_now = csr_write_data;
         end
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no word moved for %0d cycles", $time, quiet_cycles);
            $display("simulation failed");
            $finish;
         end
      end
   end

   initial begin : receiver
      forever begin
         @(posedge clock);
         if (hold_len > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold_len) @(posedge clock);
            hold_len = 0;
            rsp_stall <= 1'b0;
         end else if (stalls_on && $urandom_range(7) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(17, 1)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic send_word(input logic cmd, input int x1, input int y1, input int x2,
                            input int y2);
      if (gaps_on && $urandom_range(5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(17, 1)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_command <= cmd;
      req_start_x <= XY_BITS'(x1);
      req_start_y <= XY_BITS'(y1);
      req_end_x <= XY_BITS'(x2);
      req_end_y <= XY_BITS'(y2);
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      words_sent++;
   endtask

   task automatic wait_for_pixels();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_pen_color(input logic [COLOR_BITS-1:0] color);
      wait_for_pixels();
      csr_write_enable <= 1'b1;
      csr_write_data <= color;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic draw_line(input int x1, input int y1, input int x2, input int y2,
                            input int advances);
      send_word(CMD_START, x1, y1, x2, y2);
      repeat (advances) begin
         send_word(CMD_ADVANCE, $urandom_range(XY_MAX), $urandom_range(XY_MAX),
                   $urandom_range(XY_MAX), $urandom_range(XY_MAX));
      end
   endtask

   function automatic int pick_coord();
      case ($urandom_range(7))
         0: return 0;
         1: return XY_MAX;
         default: return $urandom_range(XY_MAX);
      endcase
   endfunction

   task automatic draw_random_line();
      int x1, y1, x2, y2, reach, offset, span, advances, choice;
      choice = $urandom_range(19);
      x1 = pick_coord();
      y1 = pick_coord();
      if (choice == 0) begin
         x2 = $urandom_range(XY_MAX);
         y2 = $urandom_range(XY_MAX);
      end else begin
         reach = $urandom_range(12);
         offset = $urandom_range(2 * reach);
         x2 = x1 + offset - reach;
         offset = $urandom_range(2 * reach);
         y2 = y1 + offset - reach;
         if (x2 < 0) x2 = 0;
         if (x2 > XY_MAX) x2 = XY_MAX;
         if (y2 < 0) y2 = 0;
         if (y2 > XY_MAX) y2 = XY_MAX;
      end
      span = (x2 > x1) ? x2 - x1 : x1 - x2;
      if (((y2 > y1) ? y2 - y1 : y1 - y2) > span) begin
         span = (y2 > y1) ? y2 - y1 : y1 - y2;
      end
      if (choice == 0) begin
         advances = $urandom_range(40, 10);
      end else if (choice <= 2) begin
         advances = $urandom_range(span);
      end else if (choice == 3) begin
         advances = span + $urandom_range(2, 1);
      end else begin
         advances = span;
      end
      draw_line(x1, y1, x2, y2, advances);
   endtask

   task automatic test_idle_advance();
      send_word(CMD_ADVANCE, XY_MAX, XY_MAX, XY_MAX, XY_MAX);
      send_word(CMD_ADVANCE, 0, 0, 0, 0);
   endtask

   task automatic test_equal_endpoints();
      draw_line(XY_MAX, 0, XY_MAX, 0, 1);
   endtask

   task automatic test_restart_active_line();
      draw_line(0, 0, XY_MAX, XY_MAX, 2);
      draw_line(XY_MAX, XY_MAX, 0, 0, 1);
   endtask

   task automatic test_octants();
      draw_line(10, 10, 8, 15, 6);
      draw_line(5, 5, 2, 8, 3);
   endtask

   task automatic test_pen_color_extremes();
      write_pen_color(32'h0000_0000);
      repeat (3) draw_random_line();
      write_pen_color(32'hFFFF_FFFF);
      repeat (3) draw_random_line();
      write_pen_color($urandom());
      repeat (3) draw_random_line();
   endtask

   task automatic test_output_backpressure();
      int stop;
      gaps_on = 1'b0;
      hold_len = 60;
      @(posedge clock);
      stop = words_sent + 30;
      while (words_sent < stop) draw_random_line();
      gaps_on = 1'b1;
      wait_for_pixels();
   endtask

   task automatic test_random_traffic(input int words, input bit with_gaps,
                                      input bit with_stalls);
      int stop;
      write_pen_color($urandom());
      gaps_on = with_gaps;
      stalls_on = with_stalls;
      stop = words_sent + words;
      while (words_sent < stop) begin
         if ($urandom_range(9) == 0) begin
            send_word(1'($urandom_range(1)), $urandom_range(XY_MAX), $urandom_range(XY_MAX),
                      $urandom_range(XY_MAX), $urandom_range(XY_MAX));
         end else begin
            draw_random_line();
         end
      end
   endtask

   initial begin : main
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_idle_advance();
      test_equal_endpoints();
      test_restart_active_line();
      test_octants();
      test_pen_color_extremes();
      test_output_backpressure();
      test_random_traffic(350, 1'b1, 1'b1);
      test_random_traffic(250, 1'b1, 1'b0);
      test_random_traffic(250, 1'b0, 1'b1);
      test_random_traffic(150, 1'b0, 1'b0);
      wait_for_pixels();
      if (mismatch_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
